### rtl/vbs_pkg.sv
package vbs_pkg;

  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_THRESH  = 3'd0;
  localparam logic [2:0] REG_MINM    = 3'd1;
  localparam logic [2:0] REG_FACTOR  = 3'd2;
  localparam logic [2:0] REG_SAMPLES = 3'd3;
  localparam logic [2:0] REG_WIDTH   = 3'd4;
  localparam logic [2:0] REG_HEIGHT  = 3'd5;
  localparam logic [2:0] REG_SEED    = 3'd6;

  localparam logic [7:0] MASK_FG = 8'd255;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_INIT,
    ST_READ,
    ST_MATCH,
    ST_CHANCE,
    ST_MOD,
    ST_OWN,
    ST_DIR,
    ST_NEIGH,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture item and position
    logic init_wr;   // write one init sample, step sample index
    logic rd_issue;  // issue read of current sample
    logic acc;       // accumulate match of returned sample
    logic draw;      // step the LFSR
    logic mod_start; // start modulo of the latest draw
    logic mod_step;  // one restoring step of the modulo unit
    logic own_wr;    // write own sample from modulo result
    logic dir_take;  // latch direction from latest draw
    logic neigh_wr;  // write neighbour sample from modulo result
    logic finish;    // present result and advance position
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_update;
    logic last_sample;
    logic background;
    logic mod_done;
    logic mod_zero;
    logic out_busy;
  } stat_t;

  function automatic logic [31:0] lfsr_next(input logic [31:0] s);
    lfsr_next = s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
  endfunction

endpackage

### rtl/vbs_ctrl.sv
module vbs_ctrl
  import vbs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  // Tells which modulo is running: 0 chance, 1 own index, 2 neighbour index.
  logic [1:0] mod_sel_r, mod_sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mod_sel_r <= 2'd0;
    end else begin
      state_r   <= state_nxt;
      mod_sel_r <= mod_sel_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt   = state_r;
    mod_sel_nxt = mod_sel_r;
    case (state_r)
      ST_IDLE:   if (in_valid && !stat.out_busy) state_nxt = ST_SETUP;
      ST_SETUP:  state_nxt = stat.is_update ? ST_READ :
                             (stat.last_sample ? ST_DONE : ST_INIT);
      ST_INIT:   if (stat.last_sample) state_nxt = ST_DONE;
      ST_READ:   state_nxt = ST_MATCH;
      ST_MATCH:  state_nxt = stat.last_sample ?
                             (stat.background ? ST_CHANCE : ST_DONE) : ST_READ;
      ST_CHANCE: begin
        state_nxt   = ST_MOD;
        mod_sel_nxt = 2'd0;
      end
      ST_MOD: begin
        if (stat.mod_done) begin
          case (mod_sel_r)
            2'd0:    state_nxt = stat.mod_zero ? ST_OWN : ST_DONE;
            2'd1:    state_nxt = ST_DIR;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_OWN: begin
        state_nxt   = ST_MOD;
        mod_sel_nxt = 2'd1;
      end
      ST_DIR:    state_nxt = ST_NEIGH;
      ST_NEIGH: begin
        state_nxt   = ST_MOD;
        mod_sel_nxt = 2'd2;
      end
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = !stat.out_busy;
        cmd.load = in_valid && !stat.out_busy;
      end
      ST_SETUP:  cmd.init_wr = !stat.is_update;
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        cmd.draw    = 1'b1;
      end
      ST_READ:   cmd.rd_issue = 1'b1;
      ST_MATCH:  cmd.acc = 1'b1;
      ST_CHANCE: begin
        cmd.draw      = 1'b1;
        cmd.mod_start = 1'b1;
      end
      ST_MOD: begin
        cmd.mod_step = !stat.mod_done;
        if (stat.mod_done) begin
          case (mod_sel_r)
            2'd1:    cmd.own_wr = 1'b1;
            2'd2:    cmd.neigh_wr = 1'b1;
            default: cmd.own_wr = 1'b0;
          endcase
        end
      end
      ST_OWN: begin
        cmd.draw      = 1'b1;
        cmd.mod_start = 1'b1;
      end
      ST_DIR: begin
        cmd.draw     = 1'b1;
        cmd.dir_take = 1'b1;
      end
      ST_NEIGH: begin
        cmd.draw      = 1'b1;
        cmd.mod_start = 1'b1;
      end
      ST_DONE:   cmd.finish = 1'b1;
      default:   cmd = '0;
    endcase
  end

  // A result is only presented from the completing state.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == ST_IDLE)
    else $error("finish not followed by idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_SETUP)
    else $error("load not followed by setup");
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.own_wr, cmd.neigh_wr, cmd.init_wr}))
    else $error("two store writes in one cycle");

endmodule

### rtl/vbs_datapath.sv
module vbs_datapath
  import vbs_pkg::*;
#(
  parameter int MAX_WIDTH   = 512,
  parameter int MAX_HEIGHT  = 512,
  parameter int MAX_SAMPLES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        in_command,
  input  logic [7:0]  in_pixel,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_mask,
  output logic        out_frame_last,
  input  logic [7:0]  thresh,
  input  logic [4:0]  min_m,
  input  logic [8:0]  factor,
  input  logic [4:0]  samples,
  input  logic [9:0]  fwidth,
  input  logic [9:0]  fheight,
  input  logic        seed_wr,
  input  logic [31:0] seed
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int KW = $clog2(MAX_SAMPLES);
  localparam int AW = XW + YW + KW;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_SAMPLES;

  logic [7:0] store_mem [DEPTH];
  logic [7:0] row_mem [MAX_WIDTH];

  // Clamped configuration.
  logic [12:0] w, h;
  logic [5:0]  ns;
  logic [4:0]  need;
  logic [8:0]  fac;
  always_comb begin
    w    = (fwidth == '0) ? 13'd1 : ((13'(fwidth) > 13'(MAX_WIDTH)) ?
           13'(MAX_WIDTH) : 13'(fwidth));
    h    = (fheight == '0) ? 13'd1 : ((13'(fheight) > 13'(MAX_HEIGHT)) ?
           13'(MAX_HEIGHT) : 13'(fheight));
    ns   = (samples == '0) ? 6'd1 : ((6'(samples) > 6'(MAX_SAMPLES)) ?
           6'(MAX_SAMPLES) : 6'(samples));
    need = (min_m == '0) ? 5'd1 : min_m;
    fac  = (factor == '0) ? 9'd1 : factor;
  end

  logic [12:0] col_r, row_r, x_r, y_r;
  logic [7:0]  pix_r, left_r, upleft_r, above_r;
  logic        upd_r;
  logic [5:0]  k_r, cnt_r;
  logic [31:0] lfsr_r;
  logic [7:0]  rd_data_r;
  logic [2:0]  dir_r;
  logic [1:0]  mstep_r;
  logic        mbusy_r;
  logic        out_valid_r;
  logic [7:0]  mask_r;
  logic        last_r;

  logic [12:0] x_c, y_c;
  logic [12:0] col_src, row_src;
  assign col_src = in_frame_start ? 13'd0 : col_r;
  assign row_src = in_frame_start ? 13'd0 : row_r;
  assign x_c = (col_src < w) ? col_src : w - 13'd1;
  assign y_c = (row_src < h) ? row_src : h - 13'd1;

  // Draw is the LFSR stepped once.
  logic [31:0] draw_v;
  assign draw_v = lfsr_next(lfsr_r);

  // An init sample takes two draws in one cycle: the left pick from the first
  // step and the up pick from the second.
  logic [31:0] draw2_v;
  assign draw2_v = lfsr_next(draw_v);

  // Modulo of the latest draw by factor or sample count, one bit per cycle.
  logic [8:0]  mdiv;
  assign mdiv = (mstep_r[1] ? 9'(ns) : fac);

  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    wr_data;
  logic          wr_en;
  logic [12:0]   nx, ny;
  logic [KW-1:0] mod_k;

  // Restoring modulo: the partial remainder lives in part_r and the draw
  // shifts in from the top, one bit a step.
  logic [31:0] mdraw_r;
  logic [9:0]  part_r;
  logic [9:0]  part_sh;
  logic [5:0]  mbit_r;
  assign part_sh = {part_r[8:0], mdraw_r[31]};

  always_comb begin
    mod_k = KW'(part_r);
    nx = x_r;
    ny = y_r;
    if ((dir_r == 3'd0 || dir_r == 3'd1 || dir_r == 3'd7) && x_r + 13'd1 < w)
      nx = x_r + 13'd1;
    if ((dir_r == 3'd3 || dir_r == 3'd4 || dir_r == 3'd5) && x_r != 13'd0)
      nx = x_r - 13'd1;
    if ((dir_r == 3'd1 || dir_r == 3'd2 || dir_r == 3'd3) && y_r + 13'd1 < h)
      ny = y_r + 13'd1;
    if ((dir_r == 3'd5 || dir_r == 3'd6 || dir_r == 3'd7) && y_r != 13'd0)
      ny = y_r - 13'd1;
  end

  // Store write selection.
  logic [7:0] init_v;
  always_comb begin
    case ({!draw2_v[0] && y_r != 13'd0, !draw_v[0] && x_r != 13'd0})
      2'b11:   init_v = upleft_r;
      2'b10:   init_v = above_r;
      2'b01:   init_v = left_r;
      default: init_v = pix_r;
    endcase
    wr_en   = cmd.init_wr || cmd.own_wr || cmd.neigh_wr;
    wr_data = pix_r;
    wr_addr = {YW'(y_r), XW'(x_r), KW'(k_r)};
    if (cmd.init_wr && k_r != 6'd0) wr_data = init_v;
    if (cmd.own_wr) wr_addr = {YW'(y_r), XW'(x_r), mod_k};
    if (cmd.neigh_wr) wr_addr = {YW'(ny), XW'(nx), mod_k};
    rd_addr = {YW'(y_r), XW'(x_r), KW'(k_r)};
  end

  always_ff @(posedge clk) begin
    if (wr_en) store_mem[wr_addr] <= wr_data;
    if (cmd.rd_issue) rd_data_r <= store_mem[rd_addr];
    if (cmd.load) above_r <= row_mem[XW'(x_c)];
    if (cmd.finish) row_mem[XW'(x_r)] <= pix_r;
  end

  logic [7:0] diff;
  assign diff = (pix_r > rd_data_r) ? pix_r - rd_data_r : rd_data_r - pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0; left_r <= '0; upleft_r <= '0;
      lfsr_r <= 32'd1; out_valid_r <= 1'b0; mbusy_r <= 1'b0;
      k_r <= '0; cnt_r <= '0; mbit_r <= '0; mstep_r <= '0;
    end else begin
      if (seed_wr) lfsr_r <= (seed == '0) ? 32'd1 : seed;
      else if (cmd.draw) lfsr_r <= upd_r ? draw_v : draw2_v;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.load) begin
        x_r <= x_c; y_r <= y_c; pix_r <= in_pixel; upd_r <= in_command;
        k_r <= '0; cnt_r <= '0;
      end
      // Init: sample 0 is the pixel itself; each later sample k is written with its own two draws, then k steps on.
      if (cmd.init_wr) k_r <= k_r + 6'd1;
      if (cmd.acc) begin
        if (diff < thresh) cnt_r <= cnt_r + 6'd1;
        k_r <= k_r + 6'd1;
      end
      if (cmd.mod_start) begin
        mdraw_r <= draw_v; part_r <= '0; mbit_r <= 6'd32; mbusy_r <= 1'b1;
        mstep_r[1] <= mstep_r[1] | mstep_r[0];
        mstep_r[0] <= 1'b1;
      end else if (cmd.mod_step && mbit_r != '0) begin
        part_r <= (part_sh >= 10'(mdiv)) ? part_sh - 10'(mdiv) : part_sh;
        mdraw_r <= {mdraw_r[30:0], 1'b0};
        mbit_r <= mbit_r - 6'd1;
      end
      if (cmd.dir_take) dir_r <= draw_v[2:0];
      if (cmd.finish) begin
        upleft_r <= above_r;
        left_r <= pix_r;
        out_valid_r <= 1'b1;
        mask_r <= (upd_r && !(cnt_r >= 6'(need))) ? MASK_FG : 8'd0;
        last_r <= (x_r == w - 13'd1) && (y_r == h - 13'd1);
        mstep_r <= '0;
        if (x_r + 13'd1 >= w) begin
          col_r <= '0;
          row_r <= (y_r + 13'd1 >= h) ? 13'd0 : y_r + 13'd1;
        end else begin
          col_r <= x_r + 13'd1;
          row_r <= y_r;
        end
      end
    end
  end

  assign stat.is_update   = upd_r;
  assign stat.last_sample = (k_r + 6'd1 >= ns);
  assign stat.background  = (cnt_r + 6'((diff < thresh) ? 1 : 0)) >= 6'(need);
  assign stat.mod_done    = mbusy_r && mbit_r == '0;
  assign stat.mod_zero    = part_r == '0;
  assign stat.out_busy    = out_valid_r && !out_ready;

  assign out_valid      = out_valid_r;
  assign out_mask       = mask_r;
  assign out_frame_last = last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("no result after finish");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mask == 8'd0 || out_mask == MASK_FG))
    else $error("mask not 0 or 255");
  assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != 32'd0)
    else $error("LFSR reached zero");

endmodule

### rtl/vibe_background_subtractor.sv
// Channel  | Direction | Fields
// in_      | input     | in_command, in_pixel, in_frame_start
// out_     | output    | out_mask, out_frame_last
// p        | APB       | psel/penable/pwrite/paddr/pwdata, prdata, pready
// An init item writes one sample a cycle, in the setup state and then the init state.
// An update item reads and matches each sample in turn; a background item adds
// the chance draw, and a taken update adds the own, direction and neighbour
// draws, each modulo being 32 bit-serial steps.
// Reset is synchronous and active low; the sample memory is not cleared.
// A new item is taken only in the idle state, while the output register is free or being emptied.
module vibe_background_subtractor
  import vbs_pkg::*;
#(
  parameter int MAX_WIDTH   = 512,
  parameter int MAX_HEIGHT  = 512,
  parameter int MAX_SAMPLES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_pixel,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_mask,
  output logic        out_frame_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  thresh_r;
  logic [4:0]  minm_r, samples_r;
  logic [8:0]  factor_r;
  logic [9:0]  width_r, height_r;
  logic [31:0] seed_r;
  logic        wr;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign idx = paddr[4:2];
  assign wr = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= 8'd20; minm_r <= 5'd2; factor_r <= 9'd16;
      samples_r <= 5'd16; width_r <= 10'd512; height_r <= 10'd512;
      seed_r <= 32'd1;
    end else if (wr) begin
      case (idx)
        REG_THRESH:  thresh_r  <= pwdata[7:0];
        REG_MINM:    minm_r    <= pwdata[4:0];
        REG_FACTOR:  factor_r  <= pwdata[8:0];
        REG_SAMPLES: samples_r <= pwdata[4:0];
        REG_WIDTH:   width_r   <= pwdata[9:0];
        REG_HEIGHT:  height_r  <= pwdata[9:0];
        REG_SEED:    seed_r    <= pwdata;
        default:     seed_r    <= seed_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THRESH:  prdata = 32'(thresh_r);
      REG_MINM:    prdata = 32'(minm_r);
      REG_FACTOR:  prdata = 32'(factor_r);
      REG_SAMPLES: prdata = 32'(samples_r);
      REG_WIDTH:   prdata = 32'(width_r);
      REG_HEIGHT:  prdata = 32'(height_r);
      REG_SEED:    prdata = seed_r;
      default:     prdata = '0;
    endcase
  end

  cmd_t  cmd;
  stat_t stat;

  vbs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  vbs_datapath #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_SAMPLES(MAX_SAMPLES)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_command(in_command), .in_pixel(in_pixel), .in_frame_start(in_frame_start),
    .out_valid(out_valid), .out_ready(out_ready), .out_mask(out_mask),
    .out_frame_last(out_frame_last),
    .thresh(thresh_r), .min_m(minm_r), .factor(factor_r), .samples(samples_r),
    .fwidth(width_r), .fheight(height_r),
    .seed_wr(wr && idx == REG_SEED), .seed(pwdata)
  );

endmodule
